// ----- hw/rtl/ctnt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctnt_pkg: shared types and constants for the cycle-count timebase
// Beat types for both queue interfaces, the configuration set, command,
// path and register index codes, and the fixed scaling shift.
// ----------------------------------------------------------------------------
package ctnt_pkg;

    // Left shift applied to the high product; the low product shifts right by
    // the complement against 32.
    localparam int SCALE_SHIFT = 5;
    localparam int WORD_HALF   = 32;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_RAW   = 2'd2,
        CMD_SCALE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        PATH_FWD    = 2'd0,
        PATH_BEHIND = 2'd1,
        PATH_JUMP   = 2'd2
    } t_path;

    typedef enum logic [2:0] {
        CFG_SCALE     = 3'd0,
        CFG_MAX_DELTA = 3'd1,
        CFG_RESUME    = 3'd2,
        CFG_SKEW      = 3'd3,
        CFG_USE_SKEW  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]  command;
        logic [62:0] counter_value;
    } t_in_beat;

    typedef struct packed {
        logic signed [63:0] result_value;
        logic [1:0]         delta_path;
        logic               was_capped;
        logic               jump_seen;
        logic [31:0]        cap_count;
    } t_out_beat;

    typedef struct packed {
        logic [31:0]        scale_factor;
        logic [31:0]        max_read_delta;
        logic [62:0]        resume_cap;
        logic signed [63:0] skew_offset;
        logic               use_skew;
    } t_cfg;

    // Classified beat handed from the front to the back
    typedef struct packed {
        t_cmd        cmd;
        logic [62:0] cv;
        logic [63:0] cnt;
    } t_mid;

endpackage
`default_nettype wire

// ----- hw/rtl/ctnt_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctnt_fifo: small synchronous queue
// Register-based queue with a fill count; one push and one pop per cycle.
// ----------------------------------------------------------------------------
module ctnt_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire T                           i_data,
    input  wire logic                       i_pop,
    output T                                o_data,
    output logic                            o_full,
    output logic                            o_empty,
    output logic [$clog2(DEPTH + 1) - 1:0]  o_count
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW - 1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW - 1:0] FULL = CW'(DEPTH);

    T                r_mem [DEPTH];
    logic [PW - 1:0] r_wr_ptr;
    logic [PW - 1:0] r_rd_ptr;
    logic [CW - 1:0] r_count;
    logic            push_ok;
    logic            pop_ok;

    assign o_full  = (r_count == FULL);
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    // Store the pushed beat
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/ctnt_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctnt_front: input side of the timebase
// Accepts beats, applies the skew offset, classifies the command and parks
// the beat in the queue that feeds the back end.
// ----------------------------------------------------------------------------
module ctnt_front #(
    parameter int MID_DEPTH = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire ctnt_pkg::t_in_beat i_item,
    input  wire ctnt_pkg::t_cfg    i_cfg,
    output logic                   o_full,
    input  wire logic              i_mid_pop,
    output ctnt_pkg::t_mid         o_mid,
    output logic                   o_mid_empty
);
    import ctnt_pkg::*;

    t_mid                              mid_in;
    logic [63:0]                       skew;
    logic [$clog2(MID_DEPTH + 1) - 1:0] mid_count;

    // Add skew for every command; the back end uses the raw value where needed
    always_comb begin
        skew       = i_cfg.use_skew ? i_cfg.skew_offset : 64'd0;
        mid_in.cmd = t_cmd'(i_item.command);
        mid_in.cv  = i_item.counter_value;
        mid_in.cnt = {1'b0, i_item.counter_value} + skew;
    end

    ctnt_fifo #(
        .T     (t_mid),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (mid_in),
        .i_pop   (i_mid_pop),
        .o_data  (o_mid),
        .o_full  (o_full),
        .o_empty (o_mid_empty),
        .o_count (mid_count)
    );

    // Full and count agree; the count itself is not needed here
    logic unused_count;
    assign unused_count = ^mid_count;

endmodule
`default_nettype wire

// ----- hw/rtl/ctnt_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctnt_back: execution side of the timebase
// Stage A resolves the delta against last_count, stage B forms the two
// partial products, stage C combines them, and the final add against
// time_base writes the result queue.
// ----------------------------------------------------------------------------
module ctnt_back #(
    parameter int OUT_DEPTH = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire ctnt_pkg::t_cfg                    i_cfg,
    input  wire ctnt_pkg::t_mid                    i_mid,
    input  wire logic                              i_mid_empty,
    output logic                                   o_mid_pop,
    input  wire logic [$clog2(OUT_DEPTH + 1) - 1:0] i_out_count,
    output logic                                   o_out_push,
    output ctnt_pkg::t_out_beat                    o_out_data
);
    import ctnt_pkg::*;

    localparam int CW = $clog2(OUT_DEPTH + 1);
    localparam int FW = (CW > 3) ? CW : 3;

    typedef struct packed {
        t_cmd        cmd;
        t_path       path;
        logic        capped;
        logic        jumped;
        logic [31:0] capcnt;
    } t_tag;

    // Architectural state
    logic [63:0] r_last;
    logic [63:0] r_jump;
    logic        r_jumped;
    logic [31:0] r_capcnt;
    logic [63:0] r_tb;

    // Pipeline registers
    logic        r_s1_valid, r_s2_valid, r_s3_valid;
    t_tag        r_s1_tag, r_s2_tag, r_s3_tag;
    logic [63:0] r_s1_delta;
    logic [63:0] r_s2_hi, r_s2_lo, r_s2_delta;
    logic [63:0] r_s3_val;

    // Stage A combinational
    logic        ge_last, ge_lo, over_cap;
    logic [63:0] last_lo, fwd_delta, cap_val;
    logic [63:0] n_delta, n_last, n_jump;
    logic        n_jumped;
    logic [31:0] n_capcnt;
    t_tag        n_tag;
    logic [FW - 1:0] busy;
    logic [63:0] scaled, sum;

    // Issue only when the result queue has room for everything in flight
    assign busy = FW'(i_out_count) + FW'(r_s1_valid) + FW'(r_s2_valid) + FW'(r_s3_valid);
    assign o_mid_pop = !i_mid_empty && (busy < FW'(OUT_DEPTH));

    // Resolve the delta and update the count state
    always_comb begin
        ge_last   = $signed(i_mid.cnt) >= $signed(r_last);
        last_lo   = r_last - {31'd0, i_cfg.max_read_delta, 1'b0};
        ge_lo     = $signed(i_mid.cnt) >= $signed(last_lo);
        over_cap  = !i_mid.cnt[63] && (i_mid.cnt[62:0] > i_cfg.resume_cap);
        fwd_delta = i_mid.cnt - r_last;
        cap_val   = over_cap ? {1'b0, i_cfg.resume_cap} : i_mid.cnt;

        n_delta  = fwd_delta;
        n_last   = r_last;
        n_jump   = r_jump;
        n_jumped = r_jumped;
        n_tag    = '{cmd: i_mid.cmd, path: PATH_FWD, capped: 1'b0,
                     jumped: 1'b0, capcnt: '0};

        unique case (i_mid.cmd)
            CMD_READ: begin
                if (ge_last) begin
                    n_delta = fwd_delta;
                end else if (ge_lo) begin
                    n_delta    = '0;
                    n_tag.path = PATH_BEHIND;
                end else begin
                    n_delta      = cap_val;
                    n_tag.path   = PATH_JUMP;
                    n_tag.capped = over_cap;
                end
            end
            CMD_TICK: begin
                n_last = i_mid.cnt;
                if (!ge_last) begin
                    n_delta      = cap_val;
                    n_tag.path   = PATH_JUMP;
                    n_tag.capped = over_cap;
                    n_jump       = r_jump + r_last;
                    n_jumped     = 1'b1;
                end
            end
            CMD_RAW: begin
                n_delta = {1'b0, i_mid.cv} + r_jump;
            end
            CMD_SCALE: begin
                n_delta = {1'b0, i_mid.cv};
            end
            default: begin
                n_delta = fwd_delta;
            end
        endcase

        n_capcnt     = r_capcnt + 32'(n_tag.capped);
        n_tag.jumped = n_jumped;
        n_tag.capcnt = n_capcnt;
    end

    // Combine partial products into the scaled delta and add the time base
    always_comb begin
        scaled = (r_s2_hi << SCALE_SHIFT) + (r_s2_lo >> (WORD_HALF - SCALE_SHIFT));
        sum    = r_tb + r_s3_val;
    end

    // Hold state and valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last     <= '0;
            r_jump     <= '0;
            r_jumped   <= 1'b0;
            r_capcnt   <= '0;
            r_tb       <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= o_mid_pop;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            if (o_mid_pop) begin
                r_last   <= n_last;
                r_jump   <= n_jump;
                r_jumped <= n_jumped;
                r_capcnt <= n_capcnt;
            end
            if (r_s3_valid && r_s3_tag.cmd == CMD_TICK) begin
                r_tb <= sum;
            end
        end
    end

    // Advance payload through the pipeline
    always_ff @(posedge i_clk) begin
        r_s1_tag   <= n_tag;
        r_s1_delta <= n_delta;
        r_s2_tag   <= r_s1_tag;
        r_s2_delta <= r_s1_delta;
        r_s2_hi    <= 64'(r_s1_delta[63:32]) * 64'(i_cfg.scale_factor);
        r_s2_lo    <= 64'(r_s1_delta[31:0]) * 64'(i_cfg.scale_factor);
        r_s3_tag   <= r_s2_tag;
        r_s3_val   <= (r_s2_tag.cmd == CMD_RAW) ? r_s2_delta : scaled;
    end

    // Add the time base for reads and ticks, then write the result queue
    always_comb begin
        o_out_push              = r_s3_valid;
        o_out_data.result_value = (r_s3_tag.cmd == CMD_READ || r_s3_tag.cmd == CMD_TICK)
                                  ? sum : r_s3_val;
        o_out_data.delta_path   = r_s3_tag.path;
        o_out_data.was_capped   = r_s3_tag.capped;
        o_out_data.jump_seen    = r_s3_tag.jumped;
        o_out_data.cap_count    = r_s3_tag.capcnt;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/cycle_count_to_nanosecond_timebase.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Path: a beat passes the input queue, delta resolve, partial products,
// combine and base add. Throughput: one beat per cycle, including
// back-to-back ticks and reads, as long as the result queue has room.
// Reset: synchronous active low; clears all state, queues and configuration.
// ----------------------------------------------------------------------------
// cycle_count_to_nanosecond_timebase: cycle counter to nanosecond time
// Top level: configuration registers, front end, back end and result queue.
// ----------------------------------------------------------------------------
module cycle_count_to_nanosecond_timebase #(
    parameter int MID_DEPTH = 2,
    parameter int OUT_DEPTH = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                push,
    input  wire ctnt_pkg::t_in_beat  i_item,
    output logic                     full,
    output logic                     empty,
    input  wire logic                pop,
    output ctnt_pkg::t_out_beat      o_result,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_idx,
    input  wire logic [63:0]         i_cfg_data
);
    import ctnt_pkg::*;

    t_cfg                               r_cfg;
    t_mid                               mid;
    logic                               mid_empty;
    logic                               mid_pop;
    logic                               out_push;
    t_out_beat                          out_data;
    logic                               out_full;
    logic [$clog2(OUT_DEPTH + 1) - 1:0] out_count;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SCALE:     r_cfg.scale_factor   <= i_cfg_data[31:0];
                CFG_MAX_DELTA: r_cfg.max_read_delta <= i_cfg_data[31:0];
                CFG_RESUME:    r_cfg.resume_cap     <= i_cfg_data[62:0];
                CFG_SKEW:      r_cfg.skew_offset    <= i_cfg_data;
                CFG_USE_SKEW:  r_cfg.use_skew       <= i_cfg_data[0];
                default:       r_cfg                <= r_cfg;
            endcase
        end
    end

    ctnt_front #(
        .MID_DEPTH (MID_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .i_cfg       (r_cfg),
        .o_full      (full),
        .i_mid_pop   (mid_pop),
        .o_mid       (mid),
        .o_mid_empty (mid_empty)
    );

    ctnt_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_mid       (mid),
        .i_mid_empty (mid_empty),
        .o_mid_pop   (mid_pop),
        .i_out_count (out_count),
        .o_out_push  (out_push),
        .o_out_data  (out_data)
    );

    ctnt_fifo #(
        .T     (t_out_beat),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_data),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_full  (out_full),
        .o_empty (empty),
        .o_count (out_count)
    );

    // Issue is credit-gated, so the result queue never sees a push when full
    logic unused_full;
    assign unused_full = out_full;

endmodule
`default_nettype wire

// ----- hw/rtl/ctnt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctnt_checker: port-level checks for the timebase
// Watches the top level's queue ports and result fields over time.
// ----------------------------------------------------------------------------
module ctnt_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                push,
    input wire logic                full,
    input wire logic                empty,
    input wire logic                pop,
    input wire ctnt_pkg::t_out_beat o_result
);
    import ctnt_pkg::*;

    // Reset leaves the result queue empty and the input queue not full
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not drained after reset");

    // A waiting result holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed");

    // Each beat bumps the cap count by at most one
    a_cap_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty) |=> (empty || o_result.cap_count == $past(o_result.cap_count)
            || o_result.cap_count == $past(o_result.cap_count) + 32'd1))
        else $error("cap count stepped by more than one");

    // The jump flag never clears once seen
    a_jump_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_result.jump_seen) |=> (empty || o_result.jump_seen))
        else $error("jump flag cleared");

    // Capping only happens on the jump path
    a_cap_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.was_capped) |-> (o_result.delta_path == PATH_JUMP))
        else $error("capped delta outside jump path");

endmodule

bind cycle_count_to_nanosecond_timebase ctnt_checker u_ctnt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
`default_nettype wire

// ----- dv/cycle_count_to_nanosecond_timebase_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cycle_count_to_nanosecond_timebase_test: self-checking bench for the timebase
// A driver streams command beats from a pending queue and a monitor pops
// results. Every accepted beat runs through a local timebase predictor. Each
// result is compared field by field with the oldest predicted beat. The run
// covers directed edge cases, then random phases under several configurations.
// Random gaps fall on both sides, and a long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module cycle_count_to_nanosecond_timebase_test;
    import ctnt_pkg::*;

    localparam int HOLDOFF_CYCLES  = 64;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 260;

    // DUT connections, inputs all driven from time zero
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        push       = 1'b0;
    t_in_beat    i_item     = '0;
    logic        full;
    logic        empty;
    logic        pop        = 1'b0;
    t_out_beat   o_result;
    logic        i_cfg_we   = 1'b0;
    logic [2:0]  i_cfg_idx  = '0;
    logic [63:0] i_cfg_data = '0;

    cycle_count_to_nanosecond_timebase u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_item     (i_item),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor copy of the configuration
    logic [31:0] cfg_scale    = '0;
    logic [31:0] cfg_lag      = '0;
    logic [62:0] cfg_cap      = '0;
    logic [63:0] cfg_skew     = '0;
    bit          cfg_use_skew = 1'b0;

    // Predictor copy of the timebase state
    logic [63:0] last_cnt  = '0;
    logic [63:0] base_ns   = '0;
    logic [63:0] jump_sum  = '0;
    bit          jumped    = 1'b0;
    logic [31:0] cap_total = '0;

    t_in_beat  cmd_items_q[$];
    t_out_beat ns_expect_q[$];

    // Bench control
    int err_cnt       = 0;
    int send_gap      = 0;
    int recv_gap      = 0;
    bit send_idle_en  = 1'b1;
    bit recv_idle_en  = 1'b1;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;
    logic [62:0] stim_cnt = '0;

    // Coverage tallies for the summary
    int n_items    = 0;
    int n_cmd[4]   = '{default: 0};
    int n_path[3]  = '{default: 0};
    int n_capped   = 0;
    int n_full     = 0;

    initial forever #6 i_clk = ~i_clk;

    // Fixed-point conversion: high word shifted up, low word shifted down
    function automatic logic [63:0] cycles_to_ns(logic [63:0] cycles);
        logic [63:0] hi_prod;
        logic [63:0] lo_prod;
        hi_prod = {32'd0, cycles[63:32]} * {32'd0, cfg_scale};
        lo_prod = {32'd0, cycles[31:0]} * {32'd0, cfg_scale};
        return (hi_prod << SCALE_SHIFT) + (lo_prod >> (WORD_HALF - SCALE_SHIFT));
    endfunction

    // Limit a jump-path delta to the resume cap, counting each cap
    function automatic logic [63:0] clamp_to_cap(logic [63:0] cycles, output bit hit);
        if ($signed({1'b0, cfg_cap}) < $signed(cycles)) begin
            hit       = 1'b1;
            cap_total = cap_total + 32'd1;
            return {1'b0, cfg_cap};
        end
        hit = 1'b0;
        return cycles;
    endfunction

    // Predict the result of one command beat and advance the timebase state
    function automatic t_out_beat advance_timebase(t_in_beat beat);
        t_out_beat   r;
        logic [63:0] cnt;
        logic [63:0] delta;
        bit          hit;
        t_path       path;
        cnt  = {1'b0, beat.counter_value} + (cfg_use_skew ? cfg_skew : 64'd0);
        hit  = 1'b0;
        path = PATH_FWD;
        r    = '0;
        case (t_cmd'(beat.command))
            CMD_READ: begin
                if ($signed(cnt) >= $signed(last_cnt)) begin
                    delta = cnt - last_cnt;
                end else if ($signed(cnt) >=
                             $signed(last_cnt - ({32'd0, cfg_lag} << 1))) begin
                    delta = '0;
                    path  = PATH_BEHIND;
                end else begin
                    delta = clamp_to_cap(cnt, hit);
                    path  = PATH_JUMP;
                end
                r.result_value = base_ns + cycles_to_ns(delta);
            end
            CMD_TICK: begin
                if ($signed(cnt) < $signed(last_cnt)) begin
                    delta    = clamp_to_cap(cnt, hit);
                    jump_sum = jump_sum + last_cnt;
                    jumped   = 1'b1;
                    path     = PATH_JUMP;
                end else begin
                    delta = cnt - last_cnt;
                end
                base_ns        = base_ns + cycles_to_ns(delta);
                last_cnt       = cnt;
                r.result_value = base_ns;
            end
            CMD_RAW: r.result_value = {1'b0, beat.counter_value} + jump_sum;
            default: r.result_value = cycles_to_ns({1'b0, beat.counter_value});
        endcase
        r.delta_path = path;
        r.was_capped = hit;
        r.jump_seen  = jumped;
        r.cap_count  = cap_total;
        n_items++;
        n_cmd[beat.command]++;
        if (beat.command inside {CMD_READ, CMD_TICK}) n_path[path]++;
        if (hit) n_capped++;
        return r;
    endfunction

    // Mostly short gaps, a few long ones; none when idling is off
    function automatic int pick_gap(bit en);
        int r;
        r = $urandom_range(0, 99);
        if (!en || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [63:0] rand_word64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            err_cnt++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
        end
    endfunction

    // Driver: offer the oldest pending beat, hold it while the block is full
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                ns_expect_q.push_back(advance_timebase(i_item));
                cmd_items_q.delete(0);
                send_gap = pick_gap(send_idle_en);
            end
            if (push && full) begin
                n_full++;
            end else if (send_gap > 0) begin
                send_gap--;
                push <= 1'b0;
            end else if (cmd_items_q.size() != 0) begin
                push   <= 1'b1;
                i_item <= cmd_items_q[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: check each popped beat, then stall or hold off as requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (ns_expect_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: result with nothing expected: %h", $time, o_result);
                end else begin
                    check_field("result_value", ns_expect_q[0].result_value,
                                o_result.result_value);
                    check_field("delta_path", 64'(ns_expect_q[0].delta_path),
                                64'(o_result.delta_path));
                    check_field("was_capped", 64'(ns_expect_q[0].was_capped),
                                64'(o_result.was_capped));
                    check_field("jump_seen", 64'(ns_expect_q[0].jump_seen),
                                64'(o_result.jump_seen));
                    check_field("cap_count", 64'(ns_expect_q[0].cap_count),
                                64'(o_result.cap_count));
                    ns_expect_q.delete(0);
                end
                recv_gap = pick_gap(recv_idle_en);
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (hold_served < hold_requests) begin
                hold_served++;
                hold_left = HOLDOFF_CYCLES;
                pop <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when nothing is accepted for too long
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || i_cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
            $display("cycle_count_to_nanosecond_timebase_test: done, errors");
            $finish;
        end
    end

    // Register write, mirrored into the predictor (block is idle)
    task automatic write_reg(t_cfg_idx idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_SCALE:     cfg_scale    = val[31:0];
            CFG_MAX_DELTA: cfg_lag      = val[31:0];
            CFG_RESUME:    cfg_cap      = val[62:0];
            CFG_SKEW:      cfg_skew     = val;
            CFG_USE_SKEW:  cfg_use_skew = val[0];
            default: ;
        endcase
    endtask

    task automatic set_timebase_cfg(logic [31:0] scale, logic [31:0] lag, logic [62:0] cap,
                                    logic [63:0] skew, bit use_skew);
        write_reg(CFG_SCALE, {32'd0, scale});
        write_reg(CFG_MAX_DELTA, {32'd0, lag});
        write_reg(CFG_RESUME, {1'b0, cap});
        write_reg(CFG_SKEW, skew);
        write_reg(CFG_USE_SKEW, {63'd0, use_skew});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic pick_random_cfg();
        logic [31:0] scale;
        logic [31:0] lag;
        logic [62:0] cap;
        logic [63:0] skew;
        int r;
        r = $urandom_range(0, 7);
        scale = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : $urandom();
        r = $urandom_range(0, 7);
        lag = (r < 4) ? 32'($urandom_range(0, 5000)) :
              (r == 4) ? 32'd0 : (r == 5) ? 32'hFFFF_FFFF : $urandom();
        r = $urandom_range(0, 9);
        cap = (r < 3) ? 63'($urandom_range(0, 100000)) :
              (r == 3) ? 63'd0 : (r == 4) ? {63{1'b1}} : 63'(rand_word64());
        r = $urandom_range(0, 9);
        skew = (r < 3) ? 64'(longint'($urandom_range(0, 20000)) - 10000) :
               (r == 3) ? 64'h8000_0000_0000_0000 :
               (r == 4) ? 64'h7FFF_FFFF_FFFF_FFFF : rand_word64();
        set_timebase_cfg(scale, lag, cap, skew, bit'($urandom_range(0, 1)));
    endtask

    task automatic queue_item(t_cmd cmd, logic [62:0] value);
        t_in_beat beat;
        beat.command       = cmd;
        beat.counter_value = value;
        cmd_items_q.push_back(beat);
    endtask

    // Mostly a counter that creeps forward, with lags, jumps back and noise
    task automatic queue_random_items(int n);
        t_in_beat    beat;
        logic [63:0] lag;
        int          r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            beat.command = (r < 40) ? CMD_READ : (r < 70) ? CMD_TICK :
                           (r < 85) ? CMD_RAW : CMD_SCALE;
            lag = {32'd0, cfg_lag} << 1;
            r = $urandom_range(0, 99);
            if (r < 60) begin
                beat.counter_value = stim_cnt + 63'($urandom_range(0, 5000));
            end else if (r < 78) begin
                r = $urandom_range(0, 9);
                if (r == 0) lag = lag;
                else if (r == 1) lag = lag + 64'd1;
                else lag = ((lag + 64'd3) * 64'($urandom_range(0, 100))) / 64'd100;
                beat.counter_value = stim_cnt - lag[62:0];
            end else if (r < 90) begin
                beat.counter_value = stim_cnt >> $urandom_range(1, 40);
            end else begin
                beat.counter_value = 63'(rand_word64());
            end
            if (beat.command == CMD_TICK) stim_cnt = beat.counter_value;
            cmd_items_q.push_back(beat);
        end
    endtask

    // Hold the sender until every predicted beat has come back
    task automatic wait_drained();
        while (cmd_items_q.size() != 0 || ns_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: zero scale, zero lag, zero cap
        queue_item(CMD_READ, 63'd0);
        queue_item(CMD_TICK, {63{1'b1}});
        queue_item(CMD_READ, 63'd0);
        wait_drained();

        // One cycle per nanosecond, narrow lag window, small cap
        set_timebase_cfg(32'h0800_0000, 32'd100, 63'd1000, 64'd0, 1'b0);
        queue_item(CMD_READ, 63'd0);
        queue_item(CMD_TICK, 63'd1000);
        queue_item(CMD_READ, 63'd1500);
        queue_item(CMD_READ, 63'd950);          // slightly behind
        queue_item(CMD_READ, 63'd800);          // on the lag boundary
        queue_item(CMD_READ, 63'd799);          // just past it: jump, uncapped
        queue_item(CMD_TICK, {63{1'b1}});
        queue_item(CMD_TICK, 63'd5000);         // backward tick, capped
        queue_item(CMD_READ, 63'd4000);         // far behind read, capped
        queue_item(CMD_TICK, 63'd500);          // backward tick, uncapped
        queue_item(CMD_RAW, 63'd0);
        queue_item(CMD_RAW, {63{1'b1}});
        queue_item(CMD_SCALE, {63{1'b1}});
        queue_item(CMD_SCALE, 63'd0);
        wait_drained();

        // Register extremes with the most negative skew applied
        set_timebase_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFF, {63{1'b1}},
                         64'h8000_0000_0000_0000, 1'b1);
        queue_item(CMD_TICK, 63'd0);            // negative count on the jump path
        queue_item(CMD_READ, {63{1'b1}});
        queue_item(CMD_TICK, {63{1'b1}});
        queue_item(CMD_READ, 63'd0);            // far behind, negative delta
        queue_item(CMD_SCALE, {63{1'b1}});
        queue_item(CMD_RAW, {63{1'b1}});
        wait_drained();

        // Random phases, each under its own configuration
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 1) set_timebase_cfg($urandom(), 32'd0, 63'd0, rand_word64(), 1'b1);
            else pick_random_cfg();
            send_idle_en = (p != 0);
            recv_idle_en = (p != 0) && (p != 3);
            if (p == 0) hold_requests++;
            stim_cnt = (p == 2) ? 63'h7FFF_FFFF_FFFF_0000 : 63'($urandom_range(0, 1000000));
            queue_random_items(ITEMS_PER_PHASE);
            wait_drained();
        end

        $display("covered %0d beats: %0d reads, %0d ticks, %0d raw, %0d scale; %0d full stalls",
                 n_items, n_cmd[CMD_READ], n_cmd[CMD_TICK], n_cmd[CMD_RAW],
                 n_cmd[CMD_SCALE], n_full);
        $display("delta paths forward %0d, behind %0d, jump %0d; %0d capped deltas",
                 n_path[PATH_FWD], n_path[PATH_BEHIND], n_path[PATH_JUMP], n_capped);
        if (err_cnt == 0) begin
            $display("cycle_count_to_nanosecond_timebase_test: done, clean");
        end else begin
            $display("cycle_count_to_nanosecond_timebase_test: done, errors");
        end
        $finish;
    end

endmodule
